// ===== design/lru_key_value_cache_assert.svh =====
// Assertion macros for the LRU key-value cache.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Property must hold at every rising clock edge.
`define LKVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true.
`define LKVC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int ENTRIES = 16;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int THR_W   = AGE_W + 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] MODE_GET   = 2'd0;
  localparam logic [1:0] MODE_PUT   = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Recency-touching operations (get hit, put, erase hit) run a scan, a decide step and an
// age sweep before the result; the rest skip the sweep. One transaction in flight: the
// next is taken only once the result enters the output register, so output stalls delay
// it. The scan has one key compare; scan and sweep share one age unit.
// Reset: valid bits, ages, occupancy and output valid cleared, capacity back to 16.
// Key and value stores are not cleared; slots are only read behind their valid bit.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0]            cfg_data_i,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]    key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]    value_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0]    read_value_o,
  output logic                                  evicted_o,
  output logic signed [lkvc_pkg::DATA_W-1:0]    evicted_key_o
);

  localparam int N = lkvc_pkg::ENTRIES;

  // ---------------------------------------------------------------------------
  // Sequencer state and transaction latch
  // ---------------------------------------------------------------------------
  lkvc_pkg::state_e state_q, state_d;
  logic [lkvc_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [1:0]                     mode_q;
  logic [lkvc_pkg::DATA_W-1:0]    key_q;
  logic [lkvc_pkg::DATA_W-1:0]    val_q;

  logic [lkvc_pkg::CAP_W-1:0]     capacity_q;
  logic [lkvc_pkg::OCC_W-1:0]     occ_q, occ_d;

  // Per-slot control kept in flops
  logic [N-1:0]                   valid_q;
  logic [N-1:0][lkvc_pkg::AGE_W-1:0] age_q;

  // Key / value stores, one write and one registered read port each
  logic [lkvc_pkg::DATA_W-1:0]    key_mem [N];
  logic [lkvc_pkg::DATA_W-1:0]    val_mem [N];
  logic [lkvc_pkg::IDX_W-1:0]     rd_addr;
  logic [lkvc_pkg::DATA_W-1:0]    key_rd_q;
  logic [lkvc_pkg::DATA_W-1:0]    val_rd_q;
  logic                           wr_en;
  logic [lkvc_pkg::IDX_W-1:0]     wr_addr;
  logic [lkvc_pkg::DATA_W-1:0]    wr_key;
  logic [lkvc_pkg::DATA_W-1:0]    wr_val;

  // Scan results
  logic                           match_q;
  logic [lkvc_pkg::IDX_W-1:0]     match_idx_q;
  logic [lkvc_pkg::AGE_W-1:0]     match_age_q;
  logic [lkvc_pkg::DATA_W-1:0]    match_val_q;
  logic                           free_q;
  logic [lkvc_pkg::IDX_W-1:0]     free_idx_q;
  logic                           any_q;
  logic [lkvc_pkg::AGE_W-1:0]     top_q;
  logic [lkvc_pkg::IDX_W-1:0]     old_idx_q;
  logic [lkvc_pkg::DATA_W-1:0]    old_key_q;

  // Age sweep control, set up in the decide step
  logic [lkvc_pkg::IDX_W-1:0]     tgt_q, tgt_d;
  logic [lkvc_pkg::THR_W-1:0]     thr_q, thr_d;
  logic                           dec_q, dec_d;
  logic                           tgt_valid_q, tgt_valid_d;
  logic                           do_upd;

  // Pending result
  logic                           res_hit_q, res_hit_d;
  logic [lkvc_pkg::DATA_W-1:0]    res_rv_q, res_rv_d;
  logic                           res_ev_q, res_ev_d;
  logic [lkvc_pkg::DATA_W-1:0]    res_evk_q, res_evk_d;

  // Output register
  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [lkvc_pkg::DATA_W-1:0]    out_rv_q;
  logic                           out_ev_q;
  logic [lkvc_pkg::DATA_W-1:0]    out_evk_q;

  logic in_acc;
  logic out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == lkvc_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == lkvc_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign read_value_o  = out_rv_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evk_q;

  // ---------------------------------------------------------------------------
  // Slot indexing. In the scan, count c issues the read of slot c and judges
  // slot c-1 whose key/value arrive from the registered read port.
  // ---------------------------------------------------------------------------
  logic [lkvc_pkg::IDX_W-1:0] eval_idx;
  logic [lkvc_pkg::IDX_W-1:0] upd_idx;
  logic [lkvc_pkg::IDX_W-1:0] cur_idx;
  logic                       scanning;
  logic                       eval_en;

  assign scanning = (state_q == lkvc_pkg::ST_SCAN);
  assign eval_en  = scanning && (cnt_q != '0);
  assign eval_idx = lkvc_pkg::IDX_W'(cnt_q - lkvc_pkg::CNT_W'(1));
  assign upd_idx  = cnt_q[lkvc_pkg::IDX_W-1:0];
  assign cur_idx  = scanning ? eval_idx : upd_idx;
  assign rd_addr  = (cnt_q < lkvc_pkg::CNT_W'(N)) ? cnt_q[lkvc_pkg::IDX_W-1:0] : '0;

  // ---------------------------------------------------------------------------
  // Shared age unit: one compare and one +/-1 step, used for the oldest-entry
  // search during the scan and for the recency sweep afterwards.
  // ---------------------------------------------------------------------------
  logic [lkvc_pkg::AGE_W-1:0] cur_age;
  logic                       cur_valid;
  logic [lkvc_pkg::THR_W-1:0] cmp_a, cmp_b;
  logic                       cmp_lt, cmp_eq;
  logic [lkvc_pkg::AGE_W-1:0] age_step;

  assign cur_age   = age_q[cur_idx];
  assign cur_valid = valid_q[cur_idx];
  assign cmp_a     = lkvc_pkg::THR_W'(cur_age);
  assign cmp_b     = scanning ? lkvc_pkg::THR_W'(top_q) : thr_q;
  assign cmp_lt    = (cmp_a < cmp_b);
  assign cmp_eq    = (cmp_a == cmp_b);
  assign age_step  = dec_q ? lkvc_pkg::AGE_W'(cur_age - lkvc_pkg::AGE_W'(1))
                           : lkvc_pkg::AGE_W'(cur_age + lkvc_pkg::AGE_W'(1));

  // ---------------------------------------------------------------------------
  // Effective capacity: zero acts as one, beyond the slot count clips.
  // ---------------------------------------------------------------------------
  logic [lkvc_pkg::CMP_W-1:0] cap_eff;
  logic                       room;

  always_comb begin
    cap_eff = lkvc_pkg::CMP_W'(capacity_q);
    if (capacity_q == '0) begin
      cap_eff = lkvc_pkg::CMP_W'(1);
    end else if (lkvc_pkg::CMP_W'(capacity_q) > lkvc_pkg::CMP_W'(N)) begin
      cap_eff = lkvc_pkg::CMP_W'(N);
    end
  end

  assign room = (lkvc_pkg::CMP_W'(occ_q) < cap_eff);

  // ---------------------------------------------------------------------------
  // Decide step: pick the target slot, the sweep rule and the result
  // ---------------------------------------------------------------------------
  always_comb begin
    tgt_d       = tgt_q;
    thr_d       = thr_q;
    dec_d       = dec_q;
    tgt_valid_d = tgt_valid_q;
    do_upd      = 1'b0;
    occ_d       = occ_q;
    res_hit_d   = 1'b0;
    res_rv_d    = '1;
    res_ev_d    = 1'b0;
    res_evk_d   = '0;
    wr_en       = 1'b0;
    wr_addr     = match_idx_q;
    wr_key      = key_q;
    wr_val      = val_q;

    case (mode_q)
      lkvc_pkg::MODE_GET: begin
        if (match_q) begin
          res_hit_d   = 1'b1;
          res_rv_d    = match_val_q;
          tgt_d       = match_idx_q;
          thr_d       = lkvc_pkg::THR_W'(match_age_q);
          dec_d       = 1'b0;
          tgt_valid_d = 1'b1;
          do_upd      = 1'b1;
        end
      end
      lkvc_pkg::MODE_PUT: begin
        wr_en       = 1'b1;
        dec_d       = 1'b0;
        tgt_valid_d = 1'b1;
        do_upd      = 1'b1;
        if (match_q) begin
          // refresh in place
          res_hit_d = 1'b1;
          tgt_d     = match_idx_q;
          thr_d     = lkvc_pkg::THR_W'(match_age_q);
          wr_addr   = match_idx_q;
        end else if (room && free_q) begin
          // plain insert: every live entry ages
          tgt_d   = free_idx_q;
          thr_d   = lkvc_pkg::THR_W'(N);
          wr_addr = free_idx_q;
          occ_d   = lkvc_pkg::OCC_W'(occ_q + lkvc_pkg::OCC_W'(1));
        end else if (any_q) begin
          // replace the least recent entry
          res_ev_d  = 1'b1;
          res_evk_d = old_key_q;
          tgt_d     = old_idx_q;
          thr_d     = lkvc_pkg::THR_W'(top_q);
          wr_addr   = old_idx_q;
        end else begin
          // nothing live at all: insert at the default slot
          tgt_d   = old_idx_q;
          thr_d   = lkvc_pkg::THR_W'(N);
          wr_addr = old_idx_q;
          occ_d   = lkvc_pkg::OCC_W'(occ_q + lkvc_pkg::OCC_W'(1));
        end
      end
      lkvc_pkg::MODE_ERASE: begin
        if (match_q) begin
          res_hit_d   = 1'b1;
          tgt_d       = match_idx_q;
          thr_d       = lkvc_pkg::THR_W'(match_age_q);
          dec_d       = 1'b1;
          tgt_valid_d = 1'b0;
          do_upd      = 1'b1;
          if (occ_q != '0) begin
            occ_d = lkvc_pkg::OCC_W'(occ_q - lkvc_pkg::OCC_W'(1));
          end
        end
      end
      default: begin
        // unused mode: no change
      end
    endcase

    if (state_q != lkvc_pkg::ST_DECIDE) begin
      wr_en  = 1'b0;
      do_upd = 1'b0;
      occ_d  = occ_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = lkvc_pkg::ST_SCAN;
          cnt_d   = '0;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (cnt_q == lkvc_pkg::CNT_W'(N)) begin
          state_d = lkvc_pkg::ST_DECIDE;
          cnt_d   = '0;
        end else begin
          cnt_d = lkvc_pkg::CNT_W'(cnt_q + lkvc_pkg::CNT_W'(1));
        end
      end
      lkvc_pkg::ST_DECIDE: begin
        cnt_d   = '0;
        state_d = do_upd ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_DONE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (cnt_q == lkvc_pkg::CNT_W'(N - 1)) begin
          state_d = lkvc_pkg::ST_DONE;
          cnt_d   = '0;
        end else begin
          cnt_d = lkvc_pkg::CNT_W'(cnt_q + lkvc_pkg::CNT_W'(1));
        end
      end
      lkvc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lkvc_pkg::ST_IDLE;
      cnt_q      <= '0;
      capacity_q <= lkvc_pkg::CAP_RESET;
      occ_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot valid bits and ages; the sweep visits one slot a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
    end else if (state_q == lkvc_pkg::ST_UPDATE) begin
      if (upd_idx == tgt_q) begin
        valid_q[upd_idx] <= tgt_valid_q;
        age_q[upd_idx]   <= '0;
      end else if (cur_valid) begin
        if (!dec_q && cmp_lt) begin
          age_q[upd_idx] <= age_step;
        end else if (dec_q && !cmp_lt && !cmp_eq) begin
          age_q[upd_idx] <= age_step;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= mode_i;
      key_q     <= key_i;
      val_q     <= value_i;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      any_q     <= 1'b0;
      top_q     <= '0;
      old_idx_q <= '0;
    end else if (eval_en) begin
      if (cur_valid && (key_rd_q == key_q) && !match_q) begin
        match_q     <= 1'b1;
        match_idx_q <= eval_idx;
        match_age_q <= cur_age;
        match_val_q <= val_rd_q;
      end
      if (!cur_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= eval_idx;
      end
      // last slot with the highest age wins
      if (cur_valid && !cmp_lt) begin
        any_q     <= 1'b1;
        top_q     <= cur_age;
        old_idx_q <= eval_idx;
        old_key_q <= key_rd_q;
      end
    end

    if (state_q == lkvc_pkg::ST_DECIDE) begin
      tgt_q       <= tgt_d;
      thr_q       <= thr_d;
      dec_q       <= dec_d;
      tgt_valid_q <= tgt_valid_d;
      res_hit_q   <= res_hit_d;
      res_rv_q    <= res_rv_d;
      res_ev_q    <= res_ev_d;
      res_evk_q   <= res_evk_d;
    end

    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_rv_q  <= res_rv_q;
      out_ev_q  <= res_ev_q;
      out_evk_q <= res_evk_q;
    end
  end

  // Key / value stores
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LKVC_ASSERT(a_occ_matches_valid, (state_q == lkvc_pkg::ST_IDLE) |-> ($countones(valid_q) == occ_q), "occupancy out of step with valid bits")
  `LKVC_ASSERT_NEVER(a_occ_bound, (occ_q > lkvc_pkg::OCC_W'(N)), "occupancy above slot count")
  `LKVC_ASSERT(a_evict_not_hit, (out_valid_q && out_ev_q) |-> !out_hit_q, "eviction reported on a hit")
  `LKVC_ASSERT(a_accept_scans, in_acc |=> (state_q == lkvc_pkg::ST_SCAN), "accepted transaction did not start a scan")

endmodule

// ===== bench/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

  // Mode 3 has no package constant; the block treats it as a no-op.
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Long output hold-off, in cycles, used to back the block up.
  localparam int HOLD_CYCLES = 300;

  // One reply transaction as the cache should produce it.
  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] read_value;
    logic                        evicted;
    logic [lkvc_pkg::DATA_W-1:0] evicted_key;
  } cache_reply_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [lkvc_pkg::CAP_W-1:0]         cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [1:0]                         mode_i;
  logic signed [lkvc_pkg::DATA_W-1:0] key_i;
  logic signed [lkvc_pkg::DATA_W-1:0] value_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               hit_o;
  logic signed [lkvc_pkg::DATA_W-1:0] read_value_o;
  logic                               evicted_o;
  logic signed [lkvc_pkg::DATA_W-1:0] evicted_key_o;

  lru_key_value_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache contents, ages and capacity register
  // ---------------------------------------------------------------------------
  logic                        slot_valid [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] slot_key   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] slot_val   [lkvc_pkg::ENTRIES];
  int unsigned                 slot_age   [lkvc_pkg::ENTRIES];
  int unsigned                 fill_count;
  logic [lkvc_pkg::CAP_W-1:0]  cap_reg;

  cache_reply_t cache_replies_q[$];

  // Run bookkeeping
  int   mismatches;
  int   items_sent;
  int   replies_seen;
  int   hits_seen;
  int   evictions_seen;
  int   cfg_writes;
  bit   idle_en;
  bit   hold_req;

  // Key pool for the random phases: reuse keys so hits and evictions happen.
  logic [lkvc_pkg::DATA_W-1:0] key_pool [32];
  int                          pool_n;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_slot(input logic [lkvc_pkg::DATA_W-1:0] k);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Slot s becomes most recent; valid slots younger than it age by one.
  function automatic void promote(input int s);
    int unsigned a;
    a = slot_age[s];
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_age[i] < a) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Highest age wins; on a tie the highest index is taken.
  function automatic int oldest_slot();
    int          best;
    int unsigned top;
    best = 0;
    top  = 0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot_valid[i] && slot_age[i] >= top) begin
        top  = slot_age[i];
        best = i;
      end
    return best;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (!slot_valid[i]) return i;
    return -1;
  endfunction

  // Applies one operation to the shadow cache and returns the reply it must give.
  function automatic cache_reply_t lru_apply(input logic [1:0] op,
                                             input logic [lkvc_pkg::DATA_W-1:0] k,
                                             input logic [lkvc_pkg::DATA_W-1:0] v);
    cache_reply_t r;
    int unsigned  lim;
    int unsigned  a;
    int           s;
    int           f;
    r.hit         = 1'b0;
    r.read_value  = '1;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    // zero acts as one, anything above the slot count as the slot count
    lim = 32'(cap_reg);
    if (lim == 0) lim = 1;
    if (lim > lkvc_pkg::ENTRIES) lim = lkvc_pkg::ENTRIES;
    s = find_slot(k);
    case (op)
      lkvc_pkg::MODE_GET: begin
        if (s >= 0) begin
          r.hit        = 1'b1;
          r.read_value = slot_val[s];
          promote(s);
        end
      end
      lkvc_pkg::MODE_PUT: begin
        if (s >= 0) begin
          r.hit       = 1'b1;
          slot_val[s] = v;
          promote(s);
        end else begin
          // A full cache (or one whose capacity was lowered below its fill)
          // recycles the least recent slot, so occupancy does not change.
          f = (fill_count < lim) ? free_slot() : -1;
          if (f < 0) f = oldest_slot();
          if (slot_valid[f]) begin
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[f];
            promote(f);
          end else begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
              if (slot_valid[i]) slot_age[i]++;
            slot_valid[f] = 1'b1;
            slot_age[f]   = 0;
            fill_count++;
          end
          slot_key[f] = k;
          slot_val[f] = v;
        end
      end
      lkvc_pkg::MODE_ERASE: begin
        if (s >= 0) begin
          a             = slot_age[s];
          r.hit         = 1'b1;
          slot_valid[s] = 1'b0;
          slot_age[s]   = 0;
          for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > a) slot_age[i]--;
          if (fill_count > 0) fill_count--;
        end
      end
      default: ;
    endcase
    if (r.hit) hits_seen++;
    if (r.evicted) evictions_seen++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one operation and returns at the edge where it is taken.
  // Valid is left high; the next call or a drain sets it at the next negedge.
  task automatic send_op(input logic [1:0] op, input logic [lkvc_pkg::DATA_W-1:0] k,
                         input logic [lkvc_pkg::DATA_W-1:0] v);
    cache_reply_t exp_r;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    key_i      <= k;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_r = lru_apply(op, k, v);
    cache_replies_q.push_back(exp_r);
    items_sent++;
  endtask

  // Stops offering, waits for every outstanding reply, then a short pause.
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cache_replies_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_reg = c;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [lkvc_pkg::DATA_W-1:0] want,
                             input logic [lkvc_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: ready driver and checker
  // ---------------------------------------------------------------------------

  // One assignment per negedge: either a level for one cycle, or a stall held
  // over several negedges with no further assignment until it ends.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cache_reply_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cache_replies_q.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual hit=%b rv=%h ev=%b ek=%h",
                 $time, hit_o, read_value_o, evicted_o, evicted_key_o);
        mismatches++;
      end else begin
        e = cache_replies_q[0];
        cache_replies_q.delete(0);
        check_field("hit", lkvc_pkg::DATA_W'(e.hit), lkvc_pkg::DATA_W'(hit_o));
        check_field("read_value", e.read_value, read_value_o);
        check_field("evicted", lkvc_pkg::DATA_W'(e.evicted), lkvc_pkg::DATA_W'(evicted_o));
        check_field("evicted_key", e.evicted_key, evicted_key_o);
        replies_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh cache: nothing can hit, the unused mode is a no-op.
  task automatic test_empty_cache();
    send_op(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
    send_op(lkvc_pkg::MODE_ERASE, 32'h0000_0000, 32'h0);
    send_op(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Extreme keys and values, update of a present key, erase hit and miss.
  task automatic test_put_get_erase();
    send_op(lkvc_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(lkvc_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(lkvc_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(lkvc_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'h0);
    send_op(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0);
    send_op(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
    send_op(lkvc_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
    send_op(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0);
    send_op(MODE_NONE, 32'h8000_0000, 32'h0);
    send_op(lkvc_pkg::MODE_ERASE, 32'h0000_0000, 32'h0);
    send_op(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'h0);
    send_op(lkvc_pkg::MODE_ERASE, 32'h0000_0000, 32'h0);
  endtask

  // Capacity dropped below the fill, then zero, then above the slot count.
  task automatic test_capacity_edges();
    drain_pipe();
    write_capacity(5'd1);
    send_op(lkvc_pkg::MODE_PUT, 32'h0000_0001, 32'h1111_1111);
    send_op(lkvc_pkg::MODE_PUT, 32'h0000_0002, 32'h2222_2222);
    drain_pipe();
    write_capacity(5'd0);
    send_op(lkvc_pkg::MODE_PUT, 32'h0000_0003, 32'h3333_3333);
    drain_pipe();
    write_capacity(5'd31);
    send_op(lkvc_pkg::MODE_PUT, 32'h0000_0004, 32'h4444_4444);
    send_op(lkvc_pkg::MODE_GET, 32'h0000_0003, 32'h0);
  endtask

  // Output held off for a long stretch while inputs keep coming.
  task automatic test_output_backpressure();
    drain_pipe();
    write_capacity(5'd4);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_op((i % 3 == 2) ? lkvc_pkg::MODE_GET : lkvc_pkg::MODE_PUT, 32'(i % 6), $urandom);
  endtask

  task automatic fill_key_pool();
    pool_n = $urandom_range(3, 32);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = 32'h8000_0000;
        1:       key_pool[i] = 32'h7FFF_FFFF;
        2:       key_pool[i] = 32'hFFFF_FFFF;
        3:       key_pool[i] = 32'h0000_0000;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  // Mostly pooled keys so gets and erases hit; some fresh keys for misses.
  task automatic test_random_phase(input logic [lkvc_pkg::CAP_W-1:0] c, input int n);
    int                          pick;
    logic [1:0]                  op;
    logic [lkvc_pkg::DATA_W-1:0] k;
    drain_pipe();
    write_capacity(c);
    fill_key_pool();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = lkvc_pkg::MODE_GET;
      else if (pick < 78) op = lkvc_pkg::MODE_PUT;
      else if (pick < 95) op = lkvc_pkg::MODE_ERASE;
      else                op = MODE_NONE;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
      else                            k = $urandom;
      send_op(op, k, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = lkvc_pkg::MODE_GET;
    key_i       = '0;
    value_i     = '0;
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    mismatches  = 0;
    items_sent  = 0;
    replies_seen   = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    cfg_writes     = 0;
    fill_count  = 0;
    cap_reg     = lkvc_pkg::CAP_RESET;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
      slot_age[i]   = 0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_cache();
    test_put_get_erase();
    test_capacity_edges();
    test_output_backpressure();

    test_random_phase(5'd16, 110);
    test_random_phase(5'd3, 110);
    test_random_phase(5'd1, 100);
    test_random_phase(5'd0, 80);
    test_random_phase(5'd31, 110);
    test_random_phase(5'd8, 110);
    test_random_phase(5'd2, 100);
    test_random_phase(5'd17, 110);
    test_random_phase(5'($urandom_range(1, 16)), 110);
    // closing stretch runs flat out on both sides
    idle_en = 1'b0;
    test_random_phase(5'd6, 150);

    drain_pipe();
    repeat (2 * lkvc_pkg::ENTRIES + 8) @(posedge clk_i);

    $display("Covered %0d operations over %0d capacity writes, extremes included.",
             items_sent, cfg_writes);
    $display("Replies checked: %0d, hits %0d, evictions %0d, one long output stall.",
             replies_seen, hits_seen, evictions_seen);
    if (mismatches == 0 && cache_replies_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout guard, set well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("%0t ns: timeout with %0d replies outstanding", $time,
             cache_replies_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
